// ===== sv/sitf_pkg.sv =====
// ----------------------------------------------------------------------------
// sitf_pkg
// Shared types and constants for the scaled integer to binary32 event decoder.
// ----------------------------------------------------------------------------
package sitf_pkg;

  // Event opcodes
  localparam logic [1:0] OP_PITCH = 2'd0;
  localparam logic [1:0] OP_BANK  = 2'd1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DECODED   = 2'd0,
    ST_BAD_EVENT = 2'd1,
    ST_INACTIVE  = 2'd2,
    ST_BAD_MODE  = 2'd3
  } status_t;

  // Scale: |payload| * SCALE_SIG * 2^SCALE_EXP
  localparam int                 SCALE_W   = 24;
  localparam logic [SCALE_W-1:0] SCALE_SIG = SCALE_W'(11542725);
  localparam int                 SCALE_EXP = -28;
  localparam int                 EXP_BIAS  = 127;

  // Product fits in 55 bits (2^31 * scale < 2^55)
  localparam int PROD_W   = 55;
  localparam int LZC_W    = 6;
  localparam int WIDE_P   = 53;  // first rounding precision
  localparam int NARROW_P = 24;  // second rounding precision

  // Biased exponent of a product whose MSB sits at bit PROD_W-1
  localparam logic [7:0] EXP_BASE = 8'(PROD_W - 1 + SCALE_EXP + EXP_BIAS);

  // Sideband that travels with each request through the pipeline
  typedef struct packed {
    status_t status;
    logic    target;
    logic    sign;
    logic    nz;
  } side_t;

endpackage

// ===== sv/sitf_if.sv =====
// ----------------------------------------------------------------------------
// sitf_in_if / sitf_out_if
// Valid/ready channels for event requests and decoded results.
// ----------------------------------------------------------------------------
interface sitf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               vehicle_inactive;
  logic signed [31:0] payload;

  modport source (output valid, opcode, vehicle_inactive, payload, input ready);
  modport sink   (input valid, opcode, vehicle_inactive, payload, output ready);
endinterface

interface sitf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        target_field;
  logic [31:0] value_bits;
  logic        clear_rest;

  modport source (output valid, status, target_field, value_bits, clear_rest,
                  input ready);
  modport sink   (input valid, status, target_field, value_bits, clear_rest,
                  output ready);
endinterface

// ===== sv/sitf_lzc.sv =====
// ----------------------------------------------------------------------------
// sitf_lzc
// Leading-zero count of the scaled product.
// ----------------------------------------------------------------------------
module sitf_lzc import sitf_pkg::*; (
  input  logic [PROD_W-1:0] value,
  output logic [LZC_W-1:0]  count
);

  // Highest set bit wins; zero input gives 0 (result is masked later)
  always_comb begin
    count = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (value[i]) begin
        count = LZC_W'(PROD_W - 1 - i);
      end
    end
  end

endmodule

// ===== sv/scaled_int_to_float32_event_decode_core.sv =====
// ----------------------------------------------------------------------------
// scaled_int_to_float32_event_decode_core
// Decodes pitch/bank events and converts the scaled payload to binary32.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  - event requests (opcode, vehicle_inactive, signed payload),
//              valid/ready, accepted when both are high.
//   out_chan - one result per request (status, target_field, value_bits,
//              clear_rest), same handshake, in request order.
//   cfg_we / cfg_wdata - numeric_mode register, written on any edge with
//              cfg_we high; change it only while the pipeline is empty.
// Throughput: one request per cycle while out_chan.ready stays high, set
//   by the five-stage pipeline (input/abs, 32x24 multiply, normalize,
//   53-bit round, 24-bit round+pack); a request passes the stages in that
//   order and its result leaves from the stage 5 result register.
// Stalls: each stage holds while the stage after it is full and not
//   moving; bubbles close up, so in_chan.ready stays high as long as any
//   stage is free. Nothing is dropped or duplicated.
// Reset (rst_n low, synchronous): all stages empty, numeric_mode = 0.
// ----------------------------------------------------------------------------
module scaled_int_to_float32_event_decode_core import sitf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  sitf_in_if.sink           in_chan,
  sitf_out_if.source        out_chan
);

  // Numeric mode register
  logic mode_r;

  // Stage valids
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  // Stage load enables: a stage loads when it is empty or its content leaves
  logic en1, en2, en3, en4, en5;

  // Stage 1: checks and magnitude
  side_t              s1_side_r;
  logic [31:0]        s1_mag_r;
  side_t              side_nxt;
  logic [31:0]        mag_nxt;

  // Stage 2: product
  side_t              s2_side_r;
  logic [PROD_W-1:0]  s2_prod_r;
  logic [PROD_W-1:0]  prod_full;

  // Stage 3: normalized product and exponent
  side_t              s3_side_r;
  logic [PROD_W-1:0]  s3_norm_r;
  logic [7:0]         s3_exp_r;
  logic [LZC_W-1:0]   lzc;

  // Stage 4: rounded to 53 bits
  side_t              s4_side_r;
  logic [WIDE_P-1:0]  s4_sig_r;
  logic [7:0]         s4_exp_r;
  logic               rnd1;
  logic [WIDE_P:0]    sum1;

  // Stage 5: result register
  logic               rnd2;
  logic [NARROW_P:0]  sum2;
  logic [7:0]         exp2;
  logic [1:0]         status_nxt;
  logic               target_nxt;
  logic [31:0]        value_nxt;
  logic               clear_nxt;
  logic [1:0]         out_status_r;
  logic               out_target_r;
  logic [31:0]        out_value_r;
  logic               out_clear_r;

  // Handshake chain
  assign en5 = !s5_v_r || out_chan.ready;
  assign en4 = !s4_v_r || en5;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_chan.ready = en1;

  // Status priority: bad opcode, inactive vehicle, bad numeric mode
  always_comb begin
    side_nxt.target = in_chan.opcode[0];
    side_nxt.sign   = in_chan.payload[31];
    side_nxt.nz     = (in_chan.payload != '0);
    if (in_chan.opcode != OP_PITCH && in_chan.opcode != OP_BANK) begin
      side_nxt.status = ST_BAD_EVENT;
    end else if (in_chan.vehicle_inactive) begin
      side_nxt.status = ST_INACTIVE;
    end else if (mode_r) begin
      side_nxt.status = ST_BAD_MODE;
    end else begin
      side_nxt.status = ST_DECODED;
    end
    // Most negative payload gives 2^31, exact in 32 bits
    mag_nxt = in_chan.payload[31] ? (~in_chan.payload + 32'd1) : in_chan.payload;
  end

  // 32x24 constant multiply
  assign prod_full = PROD_W'(s1_mag_r) * PROD_W'(SCALE_SIG);

  sitf_lzc u_lzc (
    .value (s2_prod_r),
    .count (lzc)
  );

  // First rounding: normalized MSB at bit 54, keep 53 bits, nearest-even
  assign rnd1 = s3_norm_r[1] & (s3_norm_r[0] | s3_norm_r[2]);
  assign sum1 = {1'b0, s3_norm_r[PROD_W-1:PROD_W-WIDE_P]} + (WIDE_P+1)'(rnd1);

  // Second rounding: keep 24 of the 53 bits, nearest-even, then pack
  always_comb begin
    rnd2 = s4_sig_r[WIDE_P-NARROW_P-1]
         & ((|s4_sig_r[WIDE_P-NARROW_P-2:0]) | s4_sig_r[WIDE_P-NARROW_P]);
    sum2 = {1'b0, s4_sig_r[WIDE_P-1:WIDE_P-NARROW_P]} + (NARROW_P+1)'(rnd2);
    exp2 = s4_exp_r + 8'(sum2[NARROW_P]);
    status_nxt = s4_side_r.status;
    target_nxt = 1'b0;
    value_nxt  = '0;
    clear_nxt  = 1'b0;
    if (s4_side_r.status == ST_DECODED) begin
      target_nxt = s4_side_r.target;
      clear_nxt  = s4_side_r.nz;
      if (s4_side_r.nz) begin
        value_nxt = {s4_side_r.sign, exp2, sum2[NARROW_P-2:0]};
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (en1) begin
        s1_v_r <= in_chan.valid;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        s3_v_r <= s2_v_r;
      end
      if (en4) begin
        s4_v_r <= s3_v_r;
      end
      if (en5) begin
        s5_v_r <= s4_v_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_side_r <= side_nxt;
      s1_mag_r  <= mag_nxt;
    end
    if (en2) begin
      s2_side_r <= s1_side_r;
      s2_prod_r <= prod_full;
    end
    if (en3) begin
      s3_side_r <= s2_side_r;
      s3_norm_r <= s2_prod_r << lzc;
      s3_exp_r  <= EXP_BASE - 8'(lzc);
    end
    if (en4) begin
      s4_side_r <= s3_side_r;
      // Carry out of the first rounding means exactly 2^53
      if (sum1[WIDE_P]) begin
        s4_sig_r <= sum1[WIDE_P:1];
        s4_exp_r <= s3_exp_r + 8'd1;
      end else begin
        s4_sig_r <= sum1[WIDE_P-1:0];
        s4_exp_r <= s3_exp_r;
      end
    end
    if (en5) begin
      out_status_r <= status_nxt;
      out_target_r <= target_nxt;
      out_value_r  <= value_nxt;
      out_clear_r  <= clear_nxt;
    end
  end

  assign out_chan.valid        = s5_v_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.target_field = out_target_r;
  assign out_chan.value_bits   = out_value_r;
  assign out_chan.clear_rest   = out_clear_r;

endmodule
